>>> hw/rtl/ebrb_pkg.sv
package ebrb_pkg;

  // fixed field widths
  localparam int unsigned WordW   = 16;
  localparam int unsigned CountW  = 7;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned InDataW = 24;

  // kind of an input transaction, carried on tuser
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_PULL   = 1'b1
  } req_e;

  // classified command between front and back
  typedef struct packed {
    req_e              kind;
    logic [WordW-1:0]  word;
    logic [CountW-1:0] count;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             empty;
  } res_t;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR_HI,
    ST_READ,
    ST_EMPTY
  } back_state_e;

endpackage

>>> hw/rtl/entropy_byte_ring_buffer_unit.sv
// order: a sample's low byte is written as it leaves the command queue, its high byte
// in the following cycle; a pull's bytes pass the READ state, the registered ram read
// and the result queue, one per cycle while that queue has room; a sample holds the back
// end for both writes (one ram write port, two bytes), a pull until its bytes are read
// reset: pointers, fill count and queues clear at once; the byte store is not
// cleared and needs no clearing pass, since only written entries are ever read
module entropy_byte_ring_buffer_unit #(
  parameter int unsigned DEPTH    = 4096,
  parameter int unsigned MAX_PULL = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // sample_word[15:0], sample_valid[16], pull_count[23:17]
  input  logic        s_axis_tuser_i,  // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // data_byte[7:0]
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o   // was_empty
);
  import ebrb_pkg::*;

  logic  cmd_valid;
  logic  cmd_ready;
  cmd_t  cmd;
  res_t  res;
  req_e  kind;

  assign kind = req_e'(s_axis_tuser_i);

  // front: accept and classify
  ebrb_front #(
    .MaxPull (MAX_PULL)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_kind_i    (kind),
    .s_data_i    (s_axis_tdata_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // back: store writes and pull reads
  ebrb_back #(
    .Depth (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_res_o     (res)
  );

  assign m_axis_tdata_o = res.data;
  assign m_axis_tlast_o = res.last;
  assign m_axis_tuser_o = res.empty;

endmodule

>>> hw/rtl/ebrb_ram.sv
module ebrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ebrb_front.sv
module ebrb_front #(
  parameter int unsigned MaxPull = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  ebrb_pkg::req_e                s_kind_i,
  input  logic [ebrb_pkg::InDataW-1:0]  s_data_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output ebrb_pkg::cmd_t                cmd_o
);
  import ebrb_pkg::*;

  logic [WordW-1:0]  word;
  logic              smp_valid;
  logic [CountW-1:0] count_raw;
  logic [CountW-1:0] count_sat;
  logic              keep;
  logic              push;
  logic              pop;
  cmd_t              cmd_new;

  cmd_t              q_mem_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;

  // unpack and classify the incoming transaction
  assign word      = s_data_i[WordW-1:0];
  assign smp_valid = s_data_i[WordW];
  assign count_raw = s_data_i[WordW+1 +: CountW];
  assign count_sat = (count_raw > CountW'(MaxPull)) ? CountW'(MaxPull) : count_raw;
  // invalid samples change nothing and are dropped here
  assign keep      = (s_kind_i == REQ_PULL) || smp_valid;

  always_comb begin
    cmd_new       = '0;
    cmd_new.kind  = s_kind_i;
    cmd_new.word  = word;
    cmd_new.count = count_sat;
  end

  // two-entry command queue
  assign s_ready_o   = (cnt_q != 2'd2);
  assign push        = s_valid_i && s_ready_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> hw/rtl/ebrb_back.sv
module ebrb_back #(
  parameter int unsigned Depth = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  ebrb_pkg::cmd_t             cmd_i,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output ebrb_pkg::res_t             m_res_o
);
  import ebrb_pkg::*;

  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned FillW  = $clog2(Depth + 1);
  localparam int unsigned CmpW   = (FillW > CountW) ? FillW : CountW;
  localparam int unsigned OqDepth = 4;
  localparam int unsigned OqPtrW  = $clog2(OqDepth);
  localparam int unsigned OqCntW  = $clog2(OqDepth + 1);

  back_state_e       state_q, state_d;
  logic [AddrW-1:0]  rp_q, rp_d;
  logic [AddrW-1:0]  wp_q, wp_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [ByteW-1:0]  hi_q, hi_d;
  logic              inflight_q, inflight_d;
  logic              last_q, last_d;

  logic              ram_we;
  logic [ByteW-1:0]  ram_wdata;
  logic              ram_re;
  logic [ByteW-1:0]  ram_rdata;
  logic              room;
  logic              credit;
  logic              push_empty;
  logic [CmpW-1:0]   cnt_ext;
  logic [CmpW-1:0]   fill_ext;
  logic [CountW-1:0] take;
  logic [AddrW-1:0]  wp_next;
  logic [AddrW-1:0]  rp_next;

  res_t              oq_mem_q [OqDepth];
  logic [OqPtrW-1:0] oq_wr_q, oq_rd_q;
  logic [OqCntW-1:0] oq_cnt_q;
  logic              oq_push;
  logic              oq_pop;
  res_t              oq_in;

  // byte store
  ebrb_ram #(
    .Width (ByteW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  // pointer wrap and occupancy checks
  assign wp_next  = (wp_q == AddrW'(Depth - 1)) ? '0 : wp_q + AddrW'(1);
  assign rp_next  = (rp_q == AddrW'(Depth - 1)) ? '0 : rp_q + AddrW'(1);
  assign room     = ({1'b0, fill_q} <= (FillW + 1)'(Depth - 2));
  assign cnt_ext  = CmpW'(cmd_i.count);
  assign fill_ext = CmpW'(fill_q);
  assign take     = (cnt_ext < fill_ext) ? cmd_i.count : CountW'(fill_ext);
  assign credit   = ((oq_cnt_q + OqCntW'(inflight_q)) < OqCntW'(OqDepth));

  // sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    rem_d       = rem_q;
    hi_d        = hi_q;
    inflight_d  = 1'b0;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_wdata   = cmd_i.word[ByteW-1:0];
    ram_re      = 1'b0;
    cmd_ready_o = 1'b0;
    push_empty  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          if (cmd_i.kind == REQ_SAMPLE) begin
            if (room) begin
              ram_we  = 1'b1;
              wp_d    = wp_next;
              fill_d  = fill_q + FillW'(1);
              hi_d    = cmd_i.word[WordW-1:ByteW];
              state_d = ST_WR_HI;
            end
          end else begin
            rem_d   = take;
            state_d = (take == '0) ? ST_EMPTY : ST_READ;
          end
        end
      end
      ST_WR_HI: begin
        ram_we    = 1'b1;
        ram_wdata = hi_q;
        wp_d      = wp_next;
        fill_d    = fill_q + FillW'(1);
        state_d   = ST_IDLE;
      end
      ST_READ: begin
        if (credit) begin
          ram_re     = 1'b1;
          rp_d       = rp_next;
          fill_d     = fill_q - FillW'(1);
          rem_d      = rem_q - CountW'(1);
          inflight_d = 1'b1;
          last_d     = (rem_q == CountW'(1));
          if (rem_q == CountW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (credit && !inflight_q) begin
          push_empty = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rp_q       <= '0;
      wp_q       <= '0;
      fill_q     <= '0;
      rem_q      <= '0;
      inflight_q <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      rp_q       <= rp_d;
      wp_q       <= wp_d;
      fill_q     <= fill_d;
      rem_q      <= rem_d;
      inflight_q <= inflight_d;
      last_q     <= last_d;
    end
  end

  // high byte held for the second write cycle
  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
  end

  // result queue, fed by read data or by an empty marker
  always_comb begin
    oq_in = '0;
    if (inflight_q) begin
      oq_in.data = ram_rdata;
      oq_in.last = last_q;
    end else begin
      oq_in.last  = 1'b1;
      oq_in.empty = 1'b1;
    end
  end

  assign oq_push   = inflight_q || push_empty;
  assign m_valid_o = (oq_cnt_q != '0);
  assign oq_pop    = m_valid_o && m_ready_i;
  assign m_res_o   = oq_mem_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + OqPtrW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + OqPtrW'(1);
      end
      oq_cnt_q <= oq_cnt_q + OqCntW'(oq_push) - OqCntW'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem_q[oq_wr_q] <= oq_in;
    end
  end

endmodule

>>> hw/rtl/ebrb_checker.sv
module ebrb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [23:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o
);

  // a stalled result transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result transaction withdrawn while stalled");

  // an empty pull result closes its pull
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("empty result without tlast");

  // an empty pull result carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (m_axis_tdata_o == 8'd0))
    else $error("empty result with non-zero data");

  // nothing is offered right after reset release
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result offered straight out of reset");

endmodule

bind entropy_byte_ring_buffer_unit ebrb_checker u_ebrb_checker (.*);
